// File: rtl/core/cg2_pkg.sv
// Shared types, constants and the micro-program of the 2x2 conjugate-gradient solver.
`default_nettype none

package cg2_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_ITER_DEF  = 16;
    localparam int TOL_W         = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_LIMIT     = 2'd1;
    localparam logic [1:0] STAT_ZERO_DEN  = 2'd2;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] rhs0;
        logic signed [31:0] rhs1;
        logic signed [31:0] guess0;
        logic signed [31:0] guess1;
    } req_t;

    typedef struct packed {
        logic signed [31:0] sol0;
        logic signed [31:0] sol1;
        logic [4:0]         iterations;
        logic [1:0]         status;
    } res_t;

    // Register identifiers of the working set.
    localparam logic [4:0] R_ZERO  = 5'd0;
    localparam logic [4:0] R_M00   = 5'd1;
    localparam logic [4:0] R_M01   = 5'd2;
    localparam logic [4:0] R_M10   = 5'd3;
    localparam logic [4:0] R_M11   = 5'd4;
    localparam logic [4:0] R_B0    = 5'd5;
    localparam logic [4:0] R_B1    = 5'd6;
    localparam logic [4:0] R_X0    = 5'd7;
    localparam logic [4:0] R_X1    = 5'd8;
    localparam logic [4:0] R_R0    = 5'd9;
    localparam logic [4:0] R_R1    = 5'd10;
    localparam logic [4:0] R_P0    = 5'd11;
    localparam logic [4:0] R_P1    = 5'd12;
    localparam logic [4:0] R_AP0   = 5'd13;
    localparam logic [4:0] R_AP1   = 5'd14;
    localparam logic [4:0] R_PAP   = 5'd15;
    localparam logic [4:0] R_RR    = 5'd16;
    localparam logic [4:0] R_ALPHA = 5'd17;
    localparam logic [4:0] R_BETA  = 5'd18;
    localparam logic [4:0] R_NX0   = 5'd19;
    localparam logic [4:0] R_NX1   = 5'd20;
    localparam logic [4:0] R_NR0   = 5'd21;
    localparam logic [4:0] R_NR1   = 5'd22;
    localparam logic [4:0] R_T     = 5'd23;
    localparam logic [4:0] R_TOL   = 5'd24;
    localparam logic [4:0] R_D0    = 5'd25;
    localparam logic [4:0] R_D1    = 5'd26;
    localparam logic [4:0] R_TOL2  = 5'd27;
    localparam logic [4:0] R_RP0   = 5'd28;
    localparam logic [4:0] R_RP1   = 5'd29;

    // Micro-operation kinds.
    localparam logic [2:0] K_MAC  = 3'd0;
    localparam logic [2:0] K_DIV  = 3'd1;
    localparam logic [2:0] K_TRR  = 3'd2;
    localparam logic [2:0] K_TPAP = 3'd3;
    localparam logic [2:0] K_DIFF = 3'd4;
    localparam logic [2:0] K_CONV = 3'd5;

    localparam logic [4:0] PC_IT   = 5'd5;
    localparam logic [4:0] PC_CONV = 5'd28;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] base;
        logic [4:0] dst;
        logic       chain;
        logic       neg;
        logic       raw;
        logic       wr;
    } uop_t;

    function automatic uop_t mac(input logic [4:0] a, input logic [4:0] b,
                                 input logic [4:0] base, input logic chain,
                                 input logic neg, input logic raw,
                                 input logic wr, input logic [4:0] dst);
        uop_t u;
        u.kind  = K_MAC;
        u.a     = a;
        u.b     = b;
        u.base  = base;
        u.chain = chain;
        u.neg   = neg;
        u.raw   = raw;
        u.wr    = wr;
        u.dst   = dst;
        return u;
    endfunction

    function automatic uop_t other(input logic [2:0] kind, input logic [4:0] a,
                                   input logic [4:0] b, input logic [4:0] dst);
        uop_t u;
        u       = '0;
        u.kind  = kind;
        u.a     = a;
        u.b     = b;
        u.dst   = dst;
        u.wr    = (kind == K_DIV);
        return u;
    endfunction

    // The solver program: setup at 0..4, one iteration at 5..28.
    function automatic uop_t uop_at(input logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mac(R_TOL, R_TOL, R_ZERO, 1'b0, 1'b0, 1'b1, 1'b1, R_TOL2);
            5'd1:  u = mac(R_M00, R_X0, R_B0, 1'b0, 1'b1, 1'b0, 1'b0, R_ZERO);
            5'd2:  u = mac(R_M01, R_X1, R_ZERO, 1'b1, 1'b1, 1'b0, 1'b1, R_RP0);
            5'd3:  u = mac(R_M10, R_X0, R_B1, 1'b0, 1'b1, 1'b0, 1'b0, R_ZERO);
            5'd4:  u = mac(R_M11, R_X1, R_ZERO, 1'b1, 1'b1, 1'b0, 1'b1, R_RP1);
            5'd5:  u = mac(R_R0, R_R0, R_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, R_ZERO);
            5'd6:  u = mac(R_R1, R_R1, R_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, R_RR);
            5'd7:  u = other(K_TRR, R_ZERO, R_ZERO, R_ZERO);
            5'd8:  u = mac(R_M00, R_P0, R_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, R_ZERO);
            5'd9:  u = mac(R_M01, R_P1, R_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, R_AP0);
            5'd10: u = mac(R_M10, R_P0, R_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, R_ZERO);
            5'd11: u = mac(R_M11, R_P1, R_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, R_AP1);
            5'd12: u = mac(R_P0, R_AP0, R_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, R_ZERO);
            5'd13: u = mac(R_P1, R_AP1, R_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, R_PAP);
            5'd14: u = other(K_TPAP, R_ZERO, R_ZERO, R_ZERO);
            5'd15: u = other(K_DIV, R_RR, R_PAP, R_ALPHA);
            5'd16: u = mac(R_P0, R_ALPHA, R_X0, 1'b0, 1'b0, 1'b0, 1'b1, R_NX0);
            5'd17: u = mac(R_P1, R_ALPHA, R_X1, 1'b0, 1'b0, 1'b0, 1'b1, R_NX1);
            5'd18: u = mac(R_AP0, R_ALPHA, R_R0, 1'b0, 1'b1, 1'b0, 1'b1, R_NR0);
            5'd19: u = mac(R_AP1, R_ALPHA, R_R1, 1'b0, 1'b1, 1'b0, 1'b1, R_NR1);
            5'd20: u = mac(R_NR0, R_NR0, R_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, R_ZERO);
            5'd21: u = mac(R_NR1, R_NR1, R_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, R_T);
            5'd22: u = other(K_DIV, R_T, R_RR, R_BETA);
            5'd23: u = mac(R_P0, R_BETA, R_NR0, 1'b0, 1'b0, 1'b0, 1'b1, R_P0);
            5'd24: u = mac(R_P1, R_BETA, R_NR1, 1'b0, 1'b0, 1'b0, 1'b1, R_P1);
            5'd25: u = other(K_DIFF, R_ZERO, R_ZERO, R_ZERO);
            5'd26: u = mac(R_D0, R_D0, R_ZERO, 1'b0, 1'b0, 1'b1, 1'b0, R_ZERO);
            5'd27: u = mac(R_D1, R_D1, R_ZERO, 1'b1, 1'b0, 1'b1, 1'b0, R_ZERO);
            default: u = other(K_CONV, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/conjugate_gradient_2x2_solver.sv
// Top level of the 2x2 conjugate-gradient solver: sequencer, working registers, shared MAC.
//
// Usage: a request on req (valid/stall) carries the matrix, the right-hand side and a
// starting guess in signed fixed point with FRAC_BITS fraction bits. The block raises
// req_stall for as long as it works on a request; one result follows on res (valid/stall).
// The user must write the tolerance register over cfg_valid/cfg_ready/cfg_data only while
// the block is idle; the block does not enforce this. cfg_ready is always high. Reset
// clears the sequencer, drops res_valid and sets the tolerance to its reset value.
// Resources: one 32x32 multiplier and one bit-per-cycle divider are shared by all the
// multiply-accumulate and division steps of the algorithm. A multiply-accumulate registers
// its product, then accumulates it; a division waits in its own state until the divider is
// done. Operands at the default FRAC_BITS are in Q16.16.
// One request is in work at a time; the next is taken once the result sits in the output
// register. When the receiver stalls, the result holds there and a finished next request
// waits in its final state until the output register frees up.
`default_nettype none

module conjugate_gradient_2x2_solver
    import cg2_pkg::*;
#(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_t             req,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output res_t                  res,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [TOL_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [4:0]       pc_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       stat_reg;
    logic             fail_reg;
    logic             res_valid_reg;
    res_t             res_reg;
    logic [TOL_W-1:0] tol_reg;

    // Working set: all payload, no reset needed.
    logic signed [31:0] m00_reg, m01_reg, m10_reg, m11_reg, b0_reg, b1_reg;
    logic signed [31:0] x0_reg, x1_reg, r0_reg, r1_reg, p0_reg, p1_reg;
    logic signed [31:0] ap0_reg, ap1_reg, pap_reg, rr_reg, alpha_reg, beta_reg;
    logic signed [31:0] nx0_reg, nx1_reg, nr0_reg, nr1_reg, t_reg, d0_reg, d1_reg;
    logic [61:0]        tol2_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;

    uop_t               uop;
    logic signed [31:0] opa, opb, opbase, divnum, divden;
    logic signed [63:0] prod_sh;
    logic signed [65:0] sum;
    logic signed [31:0] sum_sat;
    logic signed [32:0] dx0, dx1;
    logic [32:0]        ad0, ad1;
    logic               step_big, conv_done, last_iter;
    logic               div_start, div_done;
    logic signed [31:0] div_quo;
    logic               wr_en;
    logic [4:0]         wr_dst;
    logic signed [31:0] wr_val;
    logic               accept, take_res, load_res;

    function automatic logic signed [31:0] pick(input logic [4:0] id);
        logic signed [31:0] v;
        unique case (id)
            R_M00:   v = m00_reg;
            R_M01:   v = m01_reg;
            R_M10:   v = m10_reg;
            R_M11:   v = m11_reg;
            R_B0:    v = b0_reg;
            R_B1:    v = b1_reg;
            R_X0:    v = x0_reg;
            R_X1:    v = x1_reg;
            R_R0:    v = r0_reg;
            R_R1:    v = r1_reg;
            R_P0:    v = p0_reg;
            R_P1:    v = p1_reg;
            R_AP0:   v = ap0_reg;
            R_AP1:   v = ap1_reg;
            R_PAP:   v = pap_reg;
            R_RR:    v = rr_reg;
            R_ALPHA: v = alpha_reg;
            R_BETA:  v = beta_reg;
            R_NX0:   v = nx0_reg;
            R_NX1:   v = nx1_reg;
            R_NR0:   v = nr0_reg;
            R_NR1:   v = nr1_reg;
            R_T:     v = t_reg;
            R_TOL:   v = {1'b0, tol_reg};
            R_D0:    v = d0_reg;
            R_D1:    v = d1_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop    = uop_at(pc_reg);
    assign opa    = pick(uop.a);
    assign opb    = pick(uop.b);
    assign opbase = pick(uop.base);
    assign divnum = opa;
    assign divden = opb;

    // Products are floored by an arithmetic shift unless the step works on raw squares.
    assign prod_sh = uop.raw ? prod_reg : (prod_reg >>> FRAC_BITS);
    assign sum     = (uop.chain ? acc_reg : 66'(opbase))
                   + (uop.neg ? -66'(prod_sh) : 66'(prod_sh));

    always_comb begin
        if (sum > 66'sd2147483647) begin
            sum_sat = 32'sh7fff_ffff;
        end
        else if (sum < -66'sd2147483648) begin
            sum_sat = 32'sh8000_0000;
        end
        else begin
            sum_sat = sum[31:0];
        end
    end

    // Step length check: each component first against the tolerance, so that the
    // exact sum of squares only runs on values that fit the multiplier.
    assign dx0      = 33'(nx0_reg) - 33'(x0_reg);
    assign dx1      = 33'(nx1_reg) - 33'(x1_reg);
    assign ad0      = dx0[32] ? 33'(-dx0) : 33'(dx0);
    assign ad1      = dx1[32] ? 33'(-dx1) : 33'(dx1);
    assign step_big = (ad0 > {2'b00, tol_reg}) || (ad1 > {2'b00, tol_reg});
    assign conv_done = !fail_reg && (acc_reg <= $signed({4'b0000, tol2_reg}));
    assign last_iter = (count_reg + CNT_W'(1)) == CNT_W'(MAX_ITERATIONS);

    assign div_start = (state_reg == ST_RUN) && (uop.kind == K_DIV);

    cg2_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (divnum),
        .den  (divden),
        .done (div_done),
        .quo  (div_quo)
    );

    assign accept   = req_valid && !req_stall;
    assign take_res = res_valid_reg && !res_stall;
    assign load_res = (state_reg == ST_FIN) && (!res_valid_reg || !res_stall);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                unique case (uop.kind)
                    K_MAC:   state_next = ST_ACC;
                    K_DIV:   state_next = ST_DIV;
                    K_TRR:   state_next = (rr_reg == '0) ? ST_FIN : ST_RUN;
                    K_TPAP:  state_next = (pap_reg == '0) ? ST_FIN : ST_RUN;
                    K_CONV:  state_next = (conv_done || last_iter) ? ST_FIN : ST_RUN;
                    default: state_next = ST_RUN;
                endcase
            end
            ST_ACC: state_next = ST_RUN;
            ST_DIV: state_next = div_done ? ST_RUN : ST_DIV;
            ST_FIN: state_next = load_res ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            count_reg     <= '0;
            stat_reg      <= STAT_LIMIT;
            fail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end
        else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end
            if (load_res) begin
                res_valid_reg <= 1'b1;
            end
            else if (take_res) begin
                res_valid_reg <= 1'b0;
            end
            if (accept) begin
                pc_reg    <= '0;
                count_reg <= '0;
                stat_reg  <= STAT_LIMIT;
            end
            else if (state_reg == ST_ACC || (state_reg == ST_DIV && div_done)) begin
                pc_reg <= pc_reg + 5'd1;
            end
            else if (state_reg == ST_RUN) begin
                unique case (uop.kind)
                    K_TRR: begin
                        if (rr_reg == '0) begin
                            stat_reg <= STAT_CONVERGED;
                        end
                        pc_reg <= pc_reg + 5'd1;
                    end
                    K_TPAP: begin
                        if (pap_reg == '0) begin
                            stat_reg <= STAT_ZERO_DEN;
                        end
                        pc_reg <= pc_reg + 5'd1;
                    end
                    K_DIFF: begin
                        fail_reg <= step_big;
                        pc_reg   <= step_big ? PC_CONV : (pc_reg + 5'd1);
                    end
                    K_CONV: begin
                        count_reg <= count_reg + CNT_W'(1);
                        pc_reg    <= PC_IT;
                        if (conv_done) begin
                            stat_reg <= STAT_CONVERGED;
                        end
                    end
                    default: begin
                        pc_reg <= pc_reg;
                    end
                endcase
            end
        end
    end

    // One register write per cycle: the end of a MAC step or a finished division.
    always_comb begin
        wr_en  = 1'b0;
        wr_dst = uop.dst;
        wr_val = sum_sat;
        if (state_reg == ST_ACC && uop.wr) begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_DIV && div_done) begin
            wr_en  = 1'b1;
            wr_val = div_quo;
        end
    end

    always_ff @(posedge clk) begin
        if (state_reg == ST_RUN && uop.kind == K_MAC) begin
            prod_reg <= 64'(opa) * 64'(opb);
        end
        if (state_reg == ST_ACC) begin
            acc_reg <= sum;
        end
        if (state_reg == ST_RUN && uop.kind == K_DIFF) begin
            d0_reg <= ad0[31:0];
            d1_reg <= ad1[31:0];
        end
        if (accept) begin
            m00_reg <= req.m00;
            m01_reg <= req.m01;
            m10_reg <= req.m10;
            m11_reg <= req.m11;
            b0_reg  <= req.rhs0;
            b1_reg  <= req.rhs1;
            x0_reg  <= req.guess0;
            x1_reg  <= req.guess1;
        end
        else if (state_reg == ST_RUN && uop.kind == K_CONV) begin
            x0_reg <= nx0_reg;
            x1_reg <= nx1_reg;
            r0_reg <= nr0_reg;
            r1_reg <= nr1_reg;
        end
        if (wr_en) begin
            unique case (wr_dst)
                R_RP0:   begin r0_reg <= wr_val; p0_reg <= wr_val; end
                R_RP1:   begin r1_reg <= wr_val; p1_reg <= wr_val; end
                R_P0:    p0_reg    <= wr_val;
                R_P1:    p1_reg    <= wr_val;
                R_AP0:   ap0_reg   <= wr_val;
                R_AP1:   ap1_reg   <= wr_val;
                R_PAP:   pap_reg   <= wr_val;
                R_RR:    rr_reg    <= wr_val;
                R_ALPHA: alpha_reg <= wr_val;
                R_BETA:  beta_reg  <= wr_val;
                R_NX0:   nx0_reg   <= wr_val;
                R_NX1:   nx1_reg   <= wr_val;
                R_NR0:   nr0_reg   <= wr_val;
                R_NR1:   nr1_reg   <= wr_val;
                R_T:     t_reg     <= wr_val;
                R_TOL2:  tol2_reg  <= sum[61:0];
                default: t_reg     <= t_reg;
            endcase
        end
        if (load_res) begin
            res_reg.sol0       <= x0_reg;
            res_reg.sol1       <= x1_reg;
            res_reg.iterations <= 5'(count_reg);
            res_reg.status     <= stat_reg;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;

    // The divider only reports back while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a division step");

    // A new result only appears out of the final state.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised without finishing a request");

    // The iteration counter never passes the limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITERATIONS))
        else $error("iteration count beyond limit");

    // Every accumulate step follows its multiply.
    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> ($past(state_reg) == ST_RUN))
        else $error("accumulate without a product");

endmodule

`default_nettype wire

// File: rtl/core/cg2_div.sv
// Restoring divider for q = (num * 2^FRAC_BITS) / den, truncated and saturated to 32 bits.
`default_nettype none

module cg2_div
    import cg2_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quo
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   rem_reg;
    logic [NW-1:0] dvd_reg;
    logic [31:0]   dsr_reg;
    logic          neg_reg;

    logic [31:0] abs_num;
    logic [31:0] abs_den;
    logic [32:0] shifted;
    logic        fits;

    assign abs_num = num[31] ? (~num + 32'd1) : num;
    assign abs_den = den[31] ? (~den + 32'd1) : den;
    assign shifted = {rem_reg, dvd_reg[NW-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= {abs_num, {FRAC_BITS{1'b0}}};
            dsr_reg <= abs_den;
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg) begin
            if (fits) begin
                rem_reg <= 32'(shifted - {1'b0, dsr_reg});
            end
            else begin
                rem_reg <= shifted[31:0];
            end
            dvd_reg <= {dvd_reg[NW-2:0], fits};
        end
    end

    // The magnitude quotient is saturated by sign before it is negated.
    always_comb begin
        if (!neg_reg) begin
            if (dvd_reg > {{(NW-32){1'b0}}, 32'h7fff_ffff}) begin
                quo = 32'sh7fff_ffff;
            end
            else begin
                quo = dvd_reg[31:0];
            end
        end
        else begin
            if (dvd_reg > {{(NW-32){1'b0}}, 32'h8000_0000}) begin
                quo = 32'sh8000_0000;
            end
            else begin
                quo = ~dvd_reg[31:0] + 32'd1;
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire
